// ===== rtl/bps_pkg.sv =====
// Shared types and constants for the beep pattern sequencer.
// No dependencies; imported by every module in rtl/.
`default_nettype none

package bps_pkg;

  localparam int TICKS_PER_SECOND = 100;
  localparam int SECONDS_W        = 8;
  localparam int MAX_LIMIT        = ((1 << SECONDS_W) - 1) * TICKS_PER_SECOND;
  localparam int TICK_W           = $clog2(MAX_LIMIT + 1);

  localparam logic [TICK_W-1:0] TICKS_PER_SECOND_V = TICK_W'(TICKS_PER_SECOND);

  // op field codes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // power level codes
  localparam logic [1:0] PWR_LOW    = 2'd0;
  localparam logic [1:0] PWR_MEDIUM = 2'd1;
  localparam logic [1:0] PWR_MAX    = 2'd2;

  localparam logic [6:0] DUTY_OFF    = 7'd0;
  localparam logic [6:0] DUTY_LOW    = 7'd25;
  localparam logic [6:0] DUTY_MEDIUM = 7'd50;
  localparam logic [6:0] DUTY_MAX    = 7'd100;

  typedef struct packed {
    logic       op;
    logic [7:0] on_seconds;
    logic [7:0] off_seconds;
    logic [7:0] beep_total;
    logic [1:0] power_level;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic [6:0] duty_percent;
    logic       done_res;
    logic       busy_res;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/bps_in_reg.sv =====
// Input register stage of the beep pattern sequencer.
// Depends on bps_pkg for the item type.
`default_nettype none

module bps_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bps_pkg::item_t in_item,
  input  wire logic          advance,
  output logic               stage_valid,
  output bps_pkg::item_t     stage_item
);
  import bps_pkg::*;

  // holds one item; refills in the same cycle it drains
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bps_core.sv =====
// Sequencer state and the single-step logic for one request or tick.
// Depends on bps_pkg for item/result types and tick counter sizing.
`default_nettype none

module bps_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step_en,
  input  wire bps_pkg::item_t item,
  output bps_pkg::result_t    result
);
  import bps_pkg::*;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_ENABLE   = 3'd1;
  localparam logic [2:0] PH_ON_WAIT  = 3'd2;
  localparam logic [2:0] PH_DISABLE  = 3'd3;
  localparam logic [2:0] PH_OFF_WAIT = 3'd4;

  logic [2:0]        phase, phase_next;
  logic [TICK_W-1:0] on_ticks, on_ticks_next;
  logic [TICK_W-1:0] off_ticks, off_ticks_next;
  logic [7:0]        beeps_done, beeps_done_next;
  logic [7:0]        held_on_seconds, held_off_seconds, held_beep_total;
  logic [1:0]        held_power;
  logic              pending_request, pending_request_next;
  logic              busy_flag, busy_flag_next;
  logic [6:0]        duty_level, duty_level_next;
  logic              take_request;
  logic              finished;

  logic [TICK_W-1:0] on_limit, off_limit, on_count, off_count;
  logic [7:0]        beeps_inc, beep_goal;
  logic [6:0]        power_duty;

  assign on_limit  = TICK_W'(held_on_seconds) * TICKS_PER_SECOND_V;
  assign off_limit = TICK_W'(held_off_seconds) * TICKS_PER_SECOND_V;
  assign on_count  = on_ticks + TICK_W'(1);
  assign off_count = off_ticks + TICK_W'(1);
  assign beeps_inc = beeps_done + 8'd1;
  assign beep_goal = (held_beep_total == 8'd0) ? 8'd1 : held_beep_total;

  always_comb begin
    case (held_power)
      PWR_LOW:    power_duty = DUTY_LOW;
      PWR_MEDIUM: power_duty = DUTY_MEDIUM;
      default:    power_duty = DUTY_MAX;
    endcase
  end

  assign take_request = (item.op == OP_REQUEST) && !busy_flag;

  always_comb begin
    phase_next           = phase;
    on_ticks_next        = on_ticks;
    off_ticks_next       = off_ticks;
    beeps_done_next      = beeps_done;
    pending_request_next = pending_request;
    busy_flag_next       = busy_flag;
    duty_level_next      = duty_level;
    finished             = 1'b0;

    if (item.op == OP_REQUEST) begin
      if (take_request) begin
        pending_request_next = 1'b1;
        busy_flag_next       = 1'b1;
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
          duty_level_next = DUTY_OFF;
          if (pending_request) begin
            pending_request_next = 1'b0;
            phase_next           = PH_ENABLE;
          end
        end
        PH_ENABLE: begin
          duty_level_next = power_duty;
          phase_next      = PH_ON_WAIT;
        end
        PH_ON_WAIT: begin
          on_ticks_next = on_count;
          if (on_count >= on_limit) begin
            on_ticks_next = '0;
            phase_next    = PH_DISABLE;
          end
        end
        PH_DISABLE: begin
          duty_level_next = DUTY_OFF;
          phase_next      = PH_OFF_WAIT;
        end
        PH_OFF_WAIT: begin
          off_ticks_next = off_count;
          if (off_count >= off_limit) begin
            off_ticks_next = '0;
            if (beeps_inc >= beep_goal) begin
              beeps_done_next = 8'd0;
              phase_next      = PH_IDLE;
              busy_flag_next  = 1'b0;
              finished        = 1'b1;
            end else begin
              beeps_done_next = beeps_inc;
              phase_next      = PH_ENABLE;
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      on_ticks         <= '0;
      off_ticks        <= '0;
      beeps_done       <= 8'd0;
      held_on_seconds  <= 8'd0;
      held_off_seconds <= 8'd0;
      held_beep_total  <= 8'd0;
      held_power       <= 2'd0;
      pending_request  <= 1'b0;
      busy_flag        <= 1'b0;
      duty_level       <= DUTY_OFF;
    end else if (step_en) begin
      phase           <= phase_next;
      on_ticks        <= on_ticks_next;
      off_ticks       <= off_ticks_next;
      beeps_done      <= beeps_done_next;
      pending_request <= pending_request_next;
      busy_flag       <= busy_flag_next;
      duty_level      <= duty_level_next;
      if (take_request) begin
        held_on_seconds  <= item.on_seconds;
        held_off_seconds <= item.off_seconds;
        held_beep_total  <= item.beep_total;
        held_power       <= item.power_level;
      end
    end
  end

  assign result.accepted     = take_request;
  assign result.duty_percent = duty_level_next;
  assign result.done_res     = finished;
  assign result.busy_res     = busy_flag_next;

  // a free block is idle with no pending request
  a_idle_when_free: assert property (@(posedge clk) disable iff (rst)
    !busy_flag |-> (phase == PH_IDLE) && !pending_request)
    else $error("not busy but sequence active");

  a_pending_only_idle: assert property (@(posedge clk) disable iff (rst)
    pending_request |-> (phase == PH_IDLE) && busy_flag)
    else $error("pending request outside idle");

  a_duty_while_sounding: assert property (@(posedge clk) disable iff (rst)
    (duty_level != DUTY_OFF) |-> (phase == PH_ON_WAIT) || (phase == PH_DISABLE))
    else $error("drive on outside beep");

  a_done_from_off_wait: assert property (@(posedge clk) disable iff (rst)
    step_en && finished |-> (phase == PH_OFF_WAIT) && busy_flag)
    else $error("done outside final off wait");

  a_on_count_phase: assert property (@(posedge clk) disable iff (rst)
    (on_ticks != '0) |-> (phase == PH_ON_WAIT) && (on_ticks < on_limit))
    else $error("on tick count out of place");

endmodule

`default_nettype wire

// ===== rtl/bps_out_reg.sv =====
// Result register of the beep pattern sequencer.
// Depends on bps_pkg for the result type.
`default_nettype none

module bps_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire bps_pkg::result_t result_in,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output bps_pkg::result_t      result_out
);
  import bps_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/beep_pattern_sequencer.sv =====
// Beep pattern sequencer top level: input register, sequencer step, result register.
// A request passes through the input stage, then the result register, before its result is valid.
// Throughput: one item per cycle; the sequencer state advances once per item in the
// step logic between the two registers, with no stall unless the result side stalls.
// Reset (rst, synchronous, active high): idle, not busy, duty 0, both stages empty.
// Depends on bps_pkg, bps_in_reg, bps_core, bps_out_reg.
`default_nettype none

module beep_pattern_sequencer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       op,
  input  wire logic [7:0] on_seconds,
  input  wire logic [7:0] off_seconds,
  input  wire logic [7:0] beep_total,
  input  wire logic [1:0] power_level,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            accepted,
  output logic [6:0]      duty_percent,
  output logic            done_res,
  output logic            busy_res
);
  import bps_pkg::*;

  item_t   in_item, stage_item;
  result_t step_result, out_result;
  logic    stage_valid, advance, step_en;

  assign in_item.op          = op;
  assign in_item.on_seconds  = on_seconds;
  assign in_item.off_seconds = off_seconds;
  assign in_item.beep_total  = beep_total;
  assign in_item.power_level = power_level;

  // stage moves when the result register is empty or being drained
  assign advance = !out_valid || out_ready;
  assign step_en = stage_valid && advance;

  bps_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  bps_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .item    (stage_item),
    .result  (step_result)
  );

  bps_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (step_en),
    .result_in  (step_result),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .result_out (out_result)
  );

  assign accepted     = out_result.accepted;
  assign duty_percent = out_result.duty_percent;
  assign done_res     = out_result.done_res;
  assign busy_res     = out_result.busy_res;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for beep_pattern_sequencer: in-line predictor, scoreboard, drivers.
// Depends on bps_pkg (codes, duty values, item_t/result_t) and the RTL top level only.
// Directed sequences first, then random sequences under three idle/stall profiles.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bps_pkg::*;

  localparam logic [1:0] PWR_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int PHASE_BUDGET = 110;
  localparam int HOLD_CYCLES = 80;

  // Mirrors the sequencer state; every accepted request yields exactly one expectation.
  class beep_tracker;
    typedef enum int {SEQ_IDLE, SEQ_ENABLE, SEQ_ON_WAIT, SEQ_DISABLE, SEQ_OFF_WAIT} seq_phase_e;

    seq_phase_e  phase_now;
    int unsigned on_count;
    int unsigned off_count;
    logic [7:0]  beeps_played;
    logic [7:0]  on_secs;
    logic [7:0]  off_secs;
    logic [7:0]  beep_goal;
    logic [1:0]  power;
    bit          start_waiting;
    bit          busy;
    logic [6:0]  duty;
    result_t     expected_results[$];
    int          errors;
    int          items_counted;
    int          sequences_done;
    int          turned_away;

    function new();
      phase_now = SEQ_IDLE;
      on_count = 0;
      off_count = 0;
      beeps_played = '0;
      on_secs = '0;
      off_secs = '0;
      beep_goal = '0;
      power = PWR_LOW;
      start_waiting = 1'b0;
      busy = 1'b0;
      duty = DUTY_OFF;
      errors = 0;
      items_counted = 0;
      sequences_done = 0;
      turned_away = 0;
    endfunction

    function void note_item(item_t it);
      result_t     r;
      int unsigned goal;
      r = '0;
      if (it.op == OP_REQUEST) begin
        if (busy) begin
          turned_away++;
        end else begin
          on_secs = it.on_seconds;
          off_secs = it.off_seconds;
          beep_goal = it.beep_total;
          power = it.power_level;
          start_waiting = 1'b1;
          busy = 1'b1;
          r.accepted = 1'b1;
          items_counted++;
        end
      end else begin
        items_counted++;
        case (phase_now)
          SEQ_IDLE: begin
            duty = DUTY_OFF;
            if (start_waiting) begin
              start_waiting = 1'b0;
              phase_now = SEQ_ENABLE;
            end
          end
          SEQ_ENABLE: begin
            case (power)
              PWR_LOW:    duty = DUTY_LOW;
              PWR_MEDIUM: duty = DUTY_MEDIUM;
              default:    duty = DUTY_MAX;
            endcase
            phase_now = SEQ_ON_WAIT;
          end
          SEQ_ON_WAIT: begin
            on_count++;
            if (on_count >= int'(on_secs) * TICKS_PER_SECOND) begin
              on_count = 0;
              phase_now = SEQ_DISABLE;
            end
          end
          SEQ_DISABLE: begin
            duty = DUTY_OFF;
            phase_now = SEQ_OFF_WAIT;
          end
          default: begin
            off_count++;
            if (off_count >= int'(off_secs) * TICKS_PER_SECOND) begin
              off_count = 0;
              beeps_played++;
              // a zero count still plays one beep
              goal = (beep_goal == 8'd0) ? 1 : beep_goal;
              if (beeps_played >= goal) begin
                beeps_played = '0;
                phase_now = SEQ_IDLE;
                busy = 1'b0;
                r.done_res = 1'b1;
                sequences_done++;
              end else begin
                phase_now = SEQ_ENABLE;
              end
            end
          end
        endcase
      end
      r.duty_percent = duty;
      r.busy_res = busy;
      expected_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: %p", got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0d, actual %0d", want.accepted, got.accepted);
        errors++;
      end
      if (got.duty_percent !== want.duty_percent) begin
        $error("duty_percent: expected %0d, actual %0d", want.duty_percent, got.duty_percent);
        errors++;
      end
      if (got.done_res !== want.done_res) begin
        $error("done_res: expected %0d, actual %0d", want.done_res, got.done_res);
        errors++;
      end
      if (got.busy_res !== want.busy_res) begin
        $error("busy_res: expected %0d, actual %0d", want.busy_res, got.busy_res);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic       op;
  logic [7:0] on_seconds;
  logic [7:0] off_seconds;
  logic [7:0] beep_total;
  logic [1:0] power_level;
  logic       out_valid;
  logic       out_ready;
  logic       accepted;
  logic [6:0] duty_percent;
  logic       done_res;
  logic       busy_res;

  int          send_gap_pct;
  int          recv_gap_pct;
  bit          hold_start;
  int          hold_left;
  int          cycles;
  beep_tracker tracker;

  beep_pattern_sequencer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .on_seconds   (on_seconds),
    .off_seconds  (off_seconds),
    .beep_total   (beep_total),
    .power_level  (power_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accepted     (accepted),
    .duty_percent (duty_percent),
    .done_res     (done_res),
    .busy_res     (busy_res)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      tracker.check_result('{accepted, duty_percent, done_res, busy_res});
    end
  end

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_start) begin
        hold_start = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] on_s, input logic [7:0] off_s,
                           input logic [7:0] total, input logic [1:0] pwr);
    item_t it;
    it = '{kind, on_s, off_s, total, pwr};
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= kind;
    on_seconds <= on_s;
    off_seconds <= off_s;
    beep_total <= total;
    power_level <= pwr;
    do @(posedge clk); while (!in_ready);
    tracker.note_item(it);
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom));
  endtask

  // full-range request; only sent while busy, so it is turned away
  task automatic send_stray_request();
    send_item(OP_REQUEST, 8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom));
  endtask

  task automatic play_out();
    while (tracker.busy) begin
      if ($urandom_range(9) == 0) send_stray_request();
      send_tick();
    end
  endtask

  task automatic run_sequence();
    logic [7:0] total;
    bit         long_run;
    long_run = ($urandom_range(19) == 0);
    total = long_run ? 8'($urandom_range(20)) : 8'($urandom_range(4));
    // long counts keep zero-second waits so the run stays short
    send_item(OP_REQUEST, (!long_run && $urandom_range(7) == 0) ? 8'd1 : 8'd0,
              (!long_run && $urandom_range(7) == 0) ? 8'd1 : 8'd0, total,
              2'($urandom_range(3)));
    play_out();
    repeat ($urandom_range(2)) send_tick();
  endtask

  // broken sequences: requests and ticks mixed with no regard for the phase
  task automatic noise_burst();
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(3) != 0) begin
        send_tick();
      end else if (tracker.busy) begin
        send_stray_request();
      end else begin
        send_item(OP_REQUEST, 8'($urandom_range(1)), 8'($urandom_range(1)),
                  8'($urandom_range(3)), 2'($urandom_range(3)));
      end
    end
  endtask

  task automatic random_phase(input int budget);
    int target;
    target = tracker.items_counted + budget;
    while (tracker.items_counted < target) begin
      if ($urandom_range(9) < 7) run_sequence();
      else noise_burst();
    end
  endtask

  initial begin
    tracker = new();
    cycles = 0;
    hold_start = 1'b0;
    send_gap_pct = 8;
    recv_gap_pct = 46;
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_TICK;
    on_seconds = '0;
    off_seconds = '0;
    beep_total = '0;
    power_level = PWR_LOW;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // idle tick, then each power level with zero and non-zero waits
    send_item(OP_TICK, 8'hFF, 8'hFF, 8'hFF, PWR_UNUSED);
    send_item(OP_REQUEST, 8'd0, 8'd0, 8'd1, PWR_LOW);
    play_out();
    send_item(OP_REQUEST, 8'd0, 8'd1, 8'd0, PWR_MEDIUM);
    send_item(OP_REQUEST, 8'hFF, 8'hFF, 8'hFF, PWR_UNUSED);
    play_out();
    send_item(OP_REQUEST, 8'd1, 8'd0, 8'd1, PWR_UNUSED);
    play_out();
    send_item(OP_REQUEST, 8'd0, 8'd0, 8'd6, PWR_MAX);
    play_out();
    send_tick();

    random_phase(PHASE_BUDGET);
    send_gap_pct = 46;
    recv_gap_pct = 8;
    random_phase(PHASE_BUDGET);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_start = 1'b1;
    random_phase(PHASE_BUDGET);

    in_valid <= 1'b0;
    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run: %0d ticks and accepted requests, %0d sequences finished, %0d turned away.",
             tracker.items_counted, tracker.sequences_done, tracker.turned_away);
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
